// ----- rtl/core/gga_pkg.sv -----
`default_nettype none

package gga_pkg;

  // default values for the top level parameters
  localparam int GGA_FIELD_LIMIT = 15;
  localparam int GGA_FRAC_DIGITS = 4;

  // payload widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 31;
  localparam int INT_W   = 32;
  localparam int DIGIT_W = 4;
  localparam int MAG_W   = 30;
  localparam int POS_W   = 3;
  localparam int FC_W    = 4;

  localparam logic [MAG_W-1:0] VALUE_CAP = 30'd1000000000;

  // characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // sentence positions: the two id characters must both be G
  localparam logic [POS_W-1:0] POS_START    = 3'd1;
  localparam logic [POS_W-1:0] POS_ID_FIRST = 3'd3;
  localparam logic [POS_W-1:0] POS_ID_LAST  = 3'd4;
  localparam logic [POS_W-1:0] POS_SAT      = 3'd5;

  // field counts whose closing comma gives a result, and the count at which fc saturates
  localparam logic [FC_W-1:0] FC_TIME = 4'd1;
  localparam logic [FC_W-1:0] FC_LAT  = 4'd2;
  localparam logic [FC_W-1:0] FC_LON  = 4'd4;
  localparam logic [FC_W-1:0] FC_SATS = 4'd7;
  localparam logic [FC_W-1:0] FC_ALT  = 4'd9;
  localparam logic [FC_W-1:0] FC_SAT  = 4'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIME = 3'd0,
    KIND_LAT  = 3'd1,
    KIND_LON  = 3'd2,
    KIND_SATS = 3'd3,
    KIND_ALT  = 3'd4
  } gga_kind_t;

  typedef struct packed {
    logic      valid;
    gga_kind_t kind;
    logic      negate;
  } gga_ctl_t;

  function automatic int gga_pow10(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic int gga_frac_w(input int n);
    return $clog2(gga_pow10(n));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gga_channels.sv -----
`default_nettype none

interface gga_rx_if;
  logic                         valid;
  logic                         ready;
  logic [gga_pkg::BYTE_W-1:0]   rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gga_res_if;
  logic                                valid;
  logic                                ready;
  logic [gga_pkg::KIND_W-1:0]          field_kind;
  logic signed [gga_pkg::VALUE_W-1:0]  field_value;
  modport source (output valid, output field_kind, output field_value, input ready);
  modport sink (input valid, input field_kind, input field_value, output ready);
endinterface

interface gga_cfg_if;
  logic valid;
  logic ready;
  logic west_longitude;
  modport source (output valid, output west_longitude, input ready);
  modport sink (input valid, input west_longitude, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gga_parser.sv -----
`default_nettype none

module gga_parser #(
  parameter int FIELD_LIMIT = gga_pkg::GGA_FIELD_LIMIT,
  parameter int FRAC_DIGITS = gga_pkg::GGA_FRAC_DIGITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  gga_rx_if.sink                                       rx,
  gga_cfg_if.sink                                      cfg,
  input  logic                                         adv,
  output gga_pkg::gga_ctl_t                            snap_ctl,
  output logic [gga_pkg::INT_W-1:0]                    snap_int,
  output logic [gga_pkg::gga_frac_w(FRAC_DIGITS)-1:0]  snap_frac,
  output logic [$clog2(FRAC_DIGITS+1)-1:0]             snap_fdig,
  output logic [gga_pkg::DIGIT_W-1:0]                  snap_first
);
  import gga_pkg::*;

  localparam int FRAC_W  = gga_frac_w(FRAC_DIGITS);
  localparam int FD_W    = $clog2(FRAC_DIGITS + 1);
  localparam int CHARS_W = $clog2(FIELD_LIMIT + 1);

  logic                in_valid;
  logic [BYTE_W-1:0]   in_byte;
  logic                west;

  logic                in_sentence, in_sentence_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [FC_W-1:0]     fc, fc_next;
  logic [CHARS_W-1:0]  chars, chars_next;
  logic [INT_W-1:0]    int_acc, int_next;
  logic [FRAC_W-1:0]   frac_acc, frac_next;
  logic [FD_W-1:0]     fdig, fdig_next;
  logic [DIGIT_W-1:0]  first, first_next;
  logic                dot, dot_next;
  logic                minus, minus_next;

  logic                go;
  logic                emit;
  gga_kind_t           kind;
  logic                negate;
  logic                id_bad;
  logic [POS_W-1:0]    pos_inc;
  logic [DIGIT_W-1:0]  digit;
  logic [INT_W+3:0]    int_wide;

  assign rx.ready  = adv;
  assign cfg.ready = 1'b1;
  assign go        = adv && in_valid;

  assign digit    = in_byte[DIGIT_W-1:0];
  assign int_wide = {4'b0, int_acc} * (INT_W+4)'(10) + (INT_W+4)'(digit);
  assign id_bad   = (pos == POS_ID_FIRST || pos == POS_ID_LAST) && in_byte != CH_G;
  assign pos_inc  = (pos == POS_SAT) ? pos : pos + 3'd1;

  always_comb begin
    in_sentence_next = in_sentence;
    pos_next         = pos;
    fc_next          = fc;
    chars_next       = chars;
    int_next         = int_acc;
    frac_next        = frac_acc;
    fdig_next        = fdig;
    first_next       = first;
    dot_next         = dot;
    minus_next       = minus;
    emit             = 1'b0;
    kind             = KIND_TIME;
    negate           = minus;

    if (in_byte == CH_DOLLAR) begin
      in_sentence_next = 1'b1;
      pos_next         = POS_START;
      fc_next          = '0;
      chars_next       = '0;
      int_next         = '0;
      frac_next        = '0;
      fdig_next        = '0;
      first_next       = '0;
      dot_next         = 1'b0;
      minus_next       = 1'b0;
    end else if (in_byte == CH_STAR) begin
      in_sentence_next = 1'b0;
      fc_next          = '0;
    end else if (in_sentence) begin
      pos_next = pos_inc;
      if (id_bad) begin
        in_sentence_next = 1'b0;
      end
      if (in_byte == CH_COMMA) begin
        case (fc)
          FC_TIME: begin
            emit = 1'b1;
            kind = KIND_TIME;
          end
          FC_LAT: begin
            emit = 1'b1;
            kind = KIND_LAT;
          end
          FC_LON: begin
            emit   = 1'b1;
            kind   = KIND_LON;
            negate = minus ^ west;
          end
          FC_SATS: begin
            emit = 1'b1;
            kind = KIND_SATS;
          end
          FC_ALT: begin
            emit = 1'b1;
            kind = KIND_ALT;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
        if (fc != FC_SAT) begin
          fc_next = fc + 4'd1;
        end
        chars_next = '0;
        int_next   = '0;
        frac_next  = '0;
        fdig_next  = '0;
        first_next = '0;
        dot_next   = 1'b0;
        minus_next = 1'b0;
      end else if (!id_bad && chars < CHARS_W'(FIELD_LIMIT)) begin
        if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
          if (!dot) begin
            int_next = (|int_wide[INT_W+3:INT_W]) ? '1 : int_wide[INT_W-1:0];
          end else if (fdig < FD_W'(FRAC_DIGITS)) begin
            frac_next = frac_acc * FRAC_W'(10) + FRAC_W'(digit);
            fdig_next = fdig + FD_W'(1);
            if (fdig == '0) begin
              first_next = digit;
            end
          end
        end else if (in_byte == CH_DOT) begin
          dot_next = 1'b1;
        end else if (in_byte == CH_MINUS && chars == '0) begin
          minus_next = 1'b1;
        end
        chars_next = chars + CHARS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= rx.valid;
    end
    if (adv && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      west        <= 1'b1;
      in_sentence <= 1'b0;
      pos         <= '0;
      fc          <= '0;
      chars       <= '0;
      int_acc     <= '0;
      frac_acc    <= '0;
      fdig        <= '0;
      first       <= '0;
      dot         <= 1'b0;
      minus       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        west <= cfg.west_longitude;
      end
      if (go) begin
        in_sentence <= in_sentence_next;
        pos         <= pos_next;
        fc          <= fc_next;
        chars       <= chars_next;
        int_acc     <= int_next;
        frac_acc    <= frac_next;
        fdig        <= fdig_next;
        first       <= first_next;
        dot         <= dot_next;
        minus       <= minus_next;
      end
    end
  end

  // snapshot of the closed field, taken before it is cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_ctl.valid <= 1'b0;
    end else if (adv) begin
      snap_ctl.valid <= go && emit;
    end
    if (go) begin
      snap_ctl.kind   <= kind;
      snap_ctl.negate <= negate;
      snap_int        <= int_acc;
      snap_frac       <= frac_acc;
      snap_fdig       <= fdig;
      snap_first      <= first;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gga_convert.sv -----
`default_nettype none

module gga_convert #(
  parameter int FRAC_DIGITS = gga_pkg::GGA_FRAC_DIGITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  gga_pkg::gga_ctl_t                            snap_ctl,
  input  logic [gga_pkg::INT_W-1:0]                    snap_int,
  input  logic [gga_pkg::gga_frac_w(FRAC_DIGITS)-1:0]  snap_frac,
  input  logic [$clog2(FRAC_DIGITS+1)-1:0]             snap_fdig,
  input  logic [gga_pkg::DIGIT_W-1:0]                  snap_first,
  gga_res_if.source                                    result,
  output logic                                         adv
);
  import gga_pkg::*;

  localparam int FRAC_W = gga_frac_w(FRAC_DIGITS);
  localparam int FD_W   = $clog2(FRAC_DIGITS + 1);
  localparam int FRAC_P = gga_pow10(FRAC_DIGITS);

  // degrees = int / 100 = (int >> 2) / 25 by reciprocal, exact for 30-bit operands
  localparam int                DEG_SH  = 35;
  localparam longint unsigned   DEG_RCP = 64'd1374389535;
  localparam int                DEG_W   = 26;
  localparam int                DEG_PW  = 61;
  localparam int                REM_W   = 7;
  localparam logic [DEG_W-1:0]  DEG_CAP = 26'd1000;
  localparam logic [MAG_W-1:0]  MICRO   = 30'd1000000;
  localparam logic [INT_W-1:0]  ALT_CAP = 32'd100000000;

  // minutes * 1e6 / (60 * 10^frac) reduced to x * num / den
  localparam int COORD_DEN = (FRAC_DIGITS <= 4) ? 3 : ((FRAC_DIGITS == 5) ? 6 : 60);
  localparam int COORD_NUM = (1000000 * COORD_DEN) / (60 * FRAC_P);
  localparam int MIN_W     = $clog2(100 * FRAC_P);
  localparam longint unsigned X_MAX = longint'(100 * FRAC_P - 1) * longint'(COORD_NUM);
  localparam int X_W       = $clog2(X_MAX + 1);
  localparam int COORD_SH  = X_W + $clog2(COORD_DEN);
  localparam longint unsigned COORD_RCP =
    ((64'd1 << COORD_SH) + longint'(COORD_DEN) - 64'd1) / longint'(COORD_DEN);
  localparam int RCP_W     = $clog2(COORD_RCP + 1);
  localparam int PR_W      = X_W + RCP_W;
  localparam int FP_W      = 21;

  gga_ctl_t            s1_ctl, s2_ctl, s3_ctl, s4_ctl;
  logic [DEG_W-1:0]    s1_deg;
  logic [REM_W-1:0]    s1_int_lo;
  logic [FRAC_W-1:0]   s1_frac;
  logic [MAG_W-1:0]    s1_plain, s2_plain, s3_plain, s4_plain;
  logic [MAG_W-1:0]    s2_degm, s3_degm, s4_degm;
  logic [MIN_W-1:0]    s2_mins;
  logic [X_W-1:0]      s3_x;
  logic [FP_W-1:0]     s4_fp;

  logic                out_valid;
  logic [DEG_PW-1:0]   deg_prod;
  logic [FD_W-1:0]     pad;
  logic [FRAC_W-1:0]   frac_scaled;
  logic [MAG_W-1:0]    plain;
  logic [REM_W-1:0]    rem;
  logic [PR_W-1:0]     fp_prod;
  logic [MAG_W:0]      coord_sum;
  logic [MAG_W-1:0]    mag;
  logic [VALUE_W-1:0]  mag_ext;
  logic                is_coord;

  assign adv          = !out_valid || result.ready;
  assign result.valid = out_valid;

  // stage 1: degrees, padded fraction, plain values
  assign deg_prod = DEG_PW'(snap_int[INT_W-1:2]) * DEG_PW'(DEG_RCP);
  assign pad      = FD_W'(FRAC_DIGITS) - snap_fdig;

  always_comb begin
    frac_scaled = snap_frac;
    for (int i = 0; i <= FRAC_DIGITS; i++) begin
      if (pad == FD_W'(i)) begin
        frac_scaled = FRAC_W'(32'(snap_frac) * 32'(gga_pow10(i)));
      end
    end
  end

  always_comb begin
    case (snap_ctl.kind)
      KIND_ALT: begin
        if (snap_int >= ALT_CAP) begin
          plain = VALUE_CAP;
        end else begin
          plain = MAG_W'(snap_int) * MAG_W'(10) + MAG_W'(snap_first);
        end
      end
      default: begin
        plain = (snap_int > INT_W'(VALUE_CAP)) ? VALUE_CAP : MAG_W'(snap_int);
      end
    endcase
  end

  // stage 2: minutes remainder from the low bits only, since it stays below 128
  assign rem = s1_int_lo - REM_W'(s1_deg[REM_W-1:0] * 7'd100);

  // stage 4: divide by the reduced denominator
  assign fp_prod = PR_W'(s3_x) * PR_W'(COORD_RCP);

  // output: sum, saturate, sign
  assign is_coord  = s4_ctl.kind == KIND_LAT || s4_ctl.kind == KIND_LON;
  assign coord_sum = {1'b0, s4_degm} + (MAG_W+1)'(s4_fp);

  always_comb begin
    if (!is_coord) begin
      mag = s4_plain;
    end else if (coord_sum > {1'b0, VALUE_CAP}) begin
      mag = VALUE_CAP;
    end else begin
      mag = coord_sum[MAG_W-1:0];
    end
  end

  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
      s2_ctl.valid <= 1'b0;
      s3_ctl.valid <= 1'b0;
      s4_ctl.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      s1_ctl.valid <= snap_ctl.valid;
      s2_ctl.valid <= s1_ctl.valid;
      s3_ctl.valid <= s2_ctl.valid;
      s4_ctl.valid <= s3_ctl.valid;
      out_valid    <= s4_ctl.valid;
    end
    if (adv) begin
      s1_ctl.kind   <= snap_ctl.kind;
      s1_ctl.negate <= snap_ctl.negate;
      s1_deg        <= deg_prod[DEG_SH +: DEG_W];
      s1_int_lo     <= snap_int[REM_W-1:0];
      s1_frac       <= frac_scaled;
      s1_plain      <= plain;

      s2_ctl.kind   <= s1_ctl.kind;
      s2_ctl.negate <= s1_ctl.negate;
      s2_degm       <= (s1_deg >= DEG_CAP) ? VALUE_CAP : MAG_W'(s1_deg) * MICRO;
      s2_mins       <= MIN_W'(rem) * MIN_W'(FRAC_P) + MIN_W'(s1_frac);
      s2_plain      <= s1_plain;

      s3_ctl.kind   <= s2_ctl.kind;
      s3_ctl.negate <= s2_ctl.negate;
      s3_x          <= X_W'(s2_mins) * X_W'(COORD_NUM);
      s3_degm       <= s2_degm;
      s3_plain      <= s2_plain;

      s4_ctl.kind   <= s3_ctl.kind;
      s4_ctl.negate <= s3_ctl.negate;
      s4_fp         <= FP_W'(fp_prod >> COORD_SH);
      s4_degm       <= s3_degm;
      s4_plain      <= s3_plain;
    end
    if (adv && s4_ctl.valid) begin
      result.field_kind  <= KIND_W'(s4_ctl.kind);
      result.field_value <= $signed(s4_ctl.negate ? (~mag_ext + VALUE_W'(1)) : mag_ext);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nmea_gga_field_parser_unit.sv -----
`default_nettype none

// channel  dir  payload                          transaction when
// rx       in   rx_byte[7:0]                     rx.valid && rx.ready
// cfg      in   west_longitude                   cfg.valid && cfg.ready
// result   out  field_kind[2:0], field_value[30:0] signed   result.valid && result.ready
//
// one byte per cycle unless the stages stall; each result follows the comma that closes its field through the pipeline
// the pipeline is input register, parse stage, four conversion stages and the result register
// all stages stall together while a result waits in the result register
// cfg is always ready; reset is synchronous, clears the parse state and sets west_longitude

module nmea_gga_field_parser_unit #(
  parameter int FIELD_LIMIT = gga_pkg::GGA_FIELD_LIMIT,
  parameter int FRAC_DIGITS = gga_pkg::GGA_FRAC_DIGITS
) (
  input  logic       clk,
  input  logic       rst,
  gga_rx_if.sink     rx,
  gga_cfg_if.sink    cfg,
  gga_res_if.source  result
);
  import gga_pkg::*;

  localparam int FRAC_W = gga_frac_w(FRAC_DIGITS);
  localparam int FD_W   = $clog2(FRAC_DIGITS + 1);

  logic                adv;
  gga_ctl_t            snap_ctl;
  logic [INT_W-1:0]    snap_int;
  logic [FRAC_W-1:0]   snap_frac;
  logic [FD_W-1:0]     snap_fdig;
  logic [DIGIT_W-1:0]  snap_first;

  gga_parser #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .adv        (adv),
    .snap_ctl   (snap_ctl),
    .snap_int   (snap_int),
    .snap_frac  (snap_frac),
    .snap_fdig  (snap_fdig),
    .snap_first (snap_first)
  );

  gga_convert #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_convert (
    .clk        (clk),
    .rst        (rst),
    .snap_ctl   (snap_ctl),
    .snap_int   (snap_int),
    .snap_frac  (snap_frac),
    .snap_fdig  (snap_fdig),
    .snap_first (snap_first),
    .result     (result),
    .adv        (adv)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;
  import gga_pkg::*;

  localparam int FIELD_LIMIT  = GGA_FIELD_LIMIT;
  localparam int FRAC_DIGITS  = GGA_FRAC_DIGITS;
  localparam int DRAIN_CYCLES = 12;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 160;
  localparam longint unsigned MAG_LIMIT = 64'd1000000000;
  localparam longint unsigned ACC_MAX   = 64'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef struct packed {
    gga_kind_t          kind;
    logic [VALUE_W-1:0] value;
  } field_res_t;

  typedef struct {
    logic [BYTE_W-1:0]  b;
    bit                 typed;
    gga_kind_t          kind;
    logic [VALUE_W-1:0] value;
  } stim_row_t;

  logic clk;
  logic rst;

  gga_rx_if  rx_ch ();
  gga_cfg_if cfg_ch ();
  gga_res_if res_ch ();

  nmea_gga_field_parser_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  // parser state mirrored on the testbench side
  bit              west = 1'b1;
  bit              in_snt = 1'b0;
  int              snt_pos = 0;
  int              fld_cnt = 0;
  int              fld_chars = 0;
  longint unsigned int_acc = 0;
  longint unsigned frac_acc = 0;
  int              frac_dig = 0;
  bit              dot_seen = 1'b0;
  bit              minus_seen = 1'b0;

  field_res_t pending_fields[$];

  int error_count = 0;
  int results_checked = 0;
  int parsed_bytes = 0;
  int sentences = 0;
  int cfg_writes = 0;
  int holds_done = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 18;
  int sink_idle_pct = 18;
  bit hold_req = 1'b0;

  // directed sequence: two sentences, one closed by a star, one with a bad id
  stim_row_t dir_tab [36] = '{
    '{8'h00,     1'b0, KIND_TIME, 31'd0},   // outside a sentence
    '{CH_DOLLAR, 1'b0, KIND_TIME, 31'd0},
    '{CH_G,      1'b0, KIND_TIME, 31'd0},
    '{"P",       1'b0, KIND_TIME, 31'd0},
    '{CH_G,      1'b0, KIND_TIME, 31'd0},
    '{CH_G,      1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b1, KIND_TIME, 31'd0},   // empty time field
    '{"9",       1'b0, KIND_TIME, 31'd0},
    '{CH_DOT,    1'b0, KIND_TIME, 31'd0},
    '{"5",       1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},   // latitude with a short fraction
    '{"N",       1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},
    '{CH_MINUS,  1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b1, KIND_LON,  31'd0},   // minus alone, negated twice
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},
    '{8'hFF,     1'b0, KIND_TIME, 31'd0},
    '{CH_MINUS,  1'b0, KIND_TIME, 31'd0},   // late minus is ignored
    '{CH_COMMA,  1'b1, KIND_SATS, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},
    '{"1",       1'b0, KIND_TIME, 31'd0},
    '{CH_DOT,    1'b0, KIND_TIME, 31'd0},
    '{"2",       1'b0, KIND_TIME, 31'd0},
    '{"3",       1'b0, KIND_TIME, 31'd0},
    '{"4",       1'b0, KIND_TIME, 31'd0},
    '{"5",       1'b0, KIND_TIME, 31'd0},
    '{"6",       1'b0, KIND_TIME, 31'd0},   // fraction digit past the limit
    '{CH_COMMA,  1'b1, KIND_ALT,  31'd12},
    '{CH_STAR,   1'b0, KIND_TIME, 31'd0},
    '{CH_DOLLAR, 1'b0, KIND_TIME, 31'd0},
    '{"1",       1'b0, KIND_TIME, 31'd0},
    '{"2",       1'b0, KIND_TIME, 31'd0},
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0},   // comma in the id rejects
    '{CH_COMMA,  1'b0, KIND_TIME, 31'd0}
  };

  function automatic longint unsigned dec_pow(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] cap_value(input longint unsigned mag, input bit negate);
    longint unsigned m;
    m = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;
    if (negate) m = ~m + 1;
    return m[VALUE_W-1:0];
  endfunction

  function automatic longint unsigned frac_pad();
    int d;
    d = (frac_dig > FRAC_DIGITS) ? FRAC_DIGITS : frac_dig;
    return frac_acc * dec_pow(FRAC_DIGITS - d);
  endfunction

  // ddmm.mmmm to micro-degrees, truncated
  function automatic longint unsigned coord_micro();
    longint unsigned deg;
    longint unsigned mins;
    deg  = int_acc / 100;
    mins = (int_acc % 100) * dec_pow(FRAC_DIGITS) + frac_pad();
    return deg * 1000000 + (mins * 1000000) / (60 * dec_pow(FRAC_DIGITS));
  endfunction

  function automatic void clear_field();
    fld_chars  = 0;
    int_acc    = 0;
    frac_acc   = 0;
    frac_dig   = 0;
    dot_seen   = 1'b0;
    minus_seen = 1'b0;
  endfunction

  function automatic void advance_pos(input logic [BYTE_W-1:0] c);
    if ((snt_pos == POS_ID_FIRST || snt_pos == POS_ID_LAST) && c != CH_G) in_snt = 1'b0;
    if (snt_pos < 15) snt_pos++;
  endfunction

  function automatic void gga_parse_byte(input logic [BYTE_W-1:0] c, output bit emit,
                                         output field_res_t res);
    bit neg;
    longint unsigned n;
    neg = minus_seen;
    emit = 1'b0;
    res.kind = KIND_TIME;
    res.value = '0;
    if (in_snt || c == CH_DOLLAR) parsed_bytes++;
    if (c == CH_DOLLAR) begin
      in_snt = 1'b1;
      snt_pos = 1;
      fld_cnt = 0;
      clear_field();
      return;
    end
    if (c == CH_STAR) begin
      in_snt = 1'b0;
      fld_cnt = 0;
      return;
    end
    if (!in_snt) return;
    if (c == CH_COMMA) begin
      emit = 1'b1;
      case (fld_cnt)
        FC_TIME: begin
          res.kind = KIND_TIME;
          res.value = cap_value(int_acc, neg);
        end
        FC_LAT: begin
          res.kind = KIND_LAT;
          res.value = cap_value(coord_micro(), neg);
        end
        FC_LON: begin
          res.kind = KIND_LON;
          res.value = cap_value(coord_micro(), neg != west);
        end
        FC_SATS: begin
          res.kind = KIND_SATS;
          res.value = cap_value(int_acc, neg);
        end
        FC_ALT: begin
          res.kind = KIND_ALT;
          res.value = cap_value(int_acc * 10 + frac_pad() / dec_pow(FRAC_DIGITS - 1), neg);
        end
        default: emit = 1'b0;
      endcase
      if (fld_cnt < 31) fld_cnt++;
      clear_field();
      advance_pos(c);
      return;
    end
    advance_pos(c);
    if (in_snt && fld_chars < FIELD_LIMIT) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!dot_seen) begin
          n = int_acc * 10 + (c - CH_ZERO);
          int_acc = (n > ACC_MAX) ? ACC_MAX : n;
        end else if (frac_dig < FRAC_DIGITS) begin
          frac_acc = frac_acc * 10 + (c - CH_ZERO);
          frac_dig++;
        end
      end else if (c == CH_DOT) begin
        dot_seen = 1'b1;
      end else if (c == CH_MINUS && fld_chars == 0) begin
        minus_seen = 1'b1;
      end
      fld_chars++;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // offers one byte, returns at the edge where the transaction happens
  task automatic drive_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    bit emit;
    field_res_t res;
    drive_byte(b);
    gga_parse_byte(b, emit, res);
    if (emit) pending_fields.push_back(res);
  endtask

  // printable filler, now and then any byte at all to break the sentence
  function automatic logic [BYTE_W-1:0] text_char();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(15) == 0) return 8'($urandom_range(255));
    c = 8'($urandom_range(33, 126));
    if (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA) c = "A";
    return c;
  endfunction

  task automatic send_field();
    int shape;
    shape = $urandom_range(15);
    if (shape == 0) return;
    if (shape == 1) begin
      repeat ($urandom_range(1, 20)) send_byte(text_char());
      return;
    end
    if ($urandom_range(7) == 0) send_byte(CH_MINUS);
    // long digit runs saturate the accumulator and, with a fraction behind them, can overrun the field limit
    repeat ((shape == 2) ? $urandom_range(9, 14) : $urandom_range(0, 5))
      send_byte(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(3) != 0) begin
      send_byte(CH_DOT);
      repeat ($urandom_range(0, 6)) send_byte(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(9) == 0) send_byte(text_char());
    end
  endtask

  task automatic send_sentence();
    int nf;
    sentences++;
    send_byte(CH_DOLLAR);
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(0, 6)) send_byte(text_char());
    end else begin
      send_byte(CH_G);
      send_byte($urandom_range(1) ? "P" : "N");
      send_byte(CH_G);
      send_byte(CH_G);
      send_byte("A");
    end
    nf = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : 14;
    repeat (nf) begin
      send_byte(CH_COMMA);
      send_field();
    end
    if ($urandom_range(5) != 0) begin
      send_byte(CH_STAR);
      send_byte(text_char());
      send_byte(text_char());
      send_byte(CH_CR);
      send_byte(CH_LF);
    end
  endtask

  task automatic run_sentences(input int n_items);
    int start;
    start = parsed_bytes;
    while (parsed_bytes - start < n_items) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
      send_sentence();
    end
  endtask

  // only while the parser is idle: drain results, then let the pipe empty
  task automatic write_west(input bit v);
    rx_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.west_longitude <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    west = v;
    cfg_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    field_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_fields.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d value %0d",
                                res_ch.field_kind, res_ch.field_value));
      end else begin
        want = pending_fields.pop_front();
        if (res_ch.field_kind !== want.kind)
          flag_mismatch($sformatf("field_kind %0d, want %0d", res_ch.field_kind, want.kind));
        if (res_ch.field_value !== want.value)
          flag_mismatch($sformatf("kind %0d field_value %0d, want %0d", want.kind,
                                  res_ch.field_value, $signed(want.value)));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    bit emit;
    field_res_t got;
    rst                   <= 1'b1;
    rx_ch.valid           <= 1'b0;
    rx_ch.rx_byte         <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.west_longitude <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset value of west_longitude
    foreach (dir_tab[i]) begin
      drive_byte(dir_tab[i].b);
      gga_parse_byte(dir_tab[i].b, emit, got);
      if (dir_tab[i].typed) pending_fields.push_back('{dir_tab[i].kind, dir_tab[i].value});
      else if (emit) pending_fields.push_back(got);
    end

    write_west(1'b0);
    run_sentences(PHASE_ITEMS);

    // no idling on either side
    write_west(1'b1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_sentences(PHASE_ITEMS);

    // output held off while bytes keep coming
    write_west(1'b0);
    src_idle_pct  = 18;
    sink_idle_pct = 18;
    hold_req      = 1'b1;
    run_sentences(PHASE_ITEMS);

    rx_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d parsed bytes in %0d random sentences, %0d results checked",
             parsed_bytes, sentences, results_checked);
    $display("west_longitude written %0d times, output held off %0d times for %0d cycles",
             cfg_writes, holds_done, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/gga_pkg.sv
rtl/core/gga_channels.sv
rtl/core/gga_parser.sv
rtl/core/gga_convert.sv
rtl/core/nmea_gga_field_parser_unit.sv
dv/tb.sv
